FILE: rtl/midpoint_line_rasterizer_assert.svh
// Assertion macros for the midpoint line rasterizer checks.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define MLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: the consequent is checked in the cycle after the antecedent.
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mlr_pkg.sv
// Shared types, widths and codes of the midpoint line rasterizer.
package mlr_pkg;

  localparam int COORD_BITS = 10;
  localparam int INC_BITS   = COORD_BITS + 3;
  localparam int DEC_BITS   = COORD_BITS + 4;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    LC_VERT        = 3'd0,
    LC_HORIZ       = 3'd1,
    LC_SHALLOW_POS = 3'd2,
    LC_STEEP_POS   = 3'd3,
    LC_SHALLOW_NEG = 3'd4,
    LC_STEEP_NEG   = 3'd5
  } line_case_e;

  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_valid;
    logic                  last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] stop_x;
    logic [COORD_BITS-1:0] stop_y;
    logic [DEC_BITS-1:0]   decision;
    logic [INC_BITS-1:0]   inc_a;
    logic [INC_BITS-1:0]   inc_b;
    line_case_e            lcase;
    logic                  active;
  } line_state_t;

endpackage

FILE: rtl/mlr_setup.sv
// Line setup: endpoint swap, case select, decision variable and increments.
module mlr_setup (
  input  mlr_pkg::in_beat_t    beat_i,
  output mlr_pkg::line_state_t state_o
);

  localparam int PAD = mlr_pkg::INC_BITS - mlr_pkg::COORD_BITS;

  logic                           swap;
  logic [mlr_pkg::COORD_BITS-1:0] x0, y0, x1, y1;
  logic signed [mlr_pkg::INC_BITS-1:0] dx, dy, neg_dy;
  logic signed [mlr_pkg::INC_BITS-1:0] dec;

  always_comb begin
    swap   = beat_i.x_start > beat_i.x_end;
    x0     = swap ? beat_i.x_end   : beat_i.x_start;
    y0     = swap ? beat_i.y_end   : beat_i.y_start;
    x1     = swap ? beat_i.x_start : beat_i.x_end;
    y1     = swap ? beat_i.y_start : beat_i.y_end;
    dx     = $signed({{PAD{1'b0}}, x1}) - $signed({{PAD{1'b0}}, x0});
    dy     = $signed({{PAD{1'b0}}, y1}) - $signed({{PAD{1'b0}}, y0});
    neg_dy = -dy;

    dec              = '0;
    state_o.cur_x    = x0;
    state_o.cur_y    = y0;
    state_o.stop_x   = x1;
    state_o.stop_y   = y1;
    state_o.inc_a    = '0;
    state_o.inc_b    = '0;
    state_o.active   = 1'b1;
    state_o.lcase    = mlr_pkg::LC_VERT;

    if (dx == '0) begin
      // vertical, walk upward from the smaller y
      state_o.lcase  = mlr_pkg::LC_VERT;
      state_o.cur_y  = (y0 < y1) ? y0 : y1;
      state_o.stop_y = (y0 < y1) ? y1 : y0;
    end else if (dy == '0) begin
      state_o.lcase = mlr_pkg::LC_HORIZ;
    end else if (dy > 0 && dy <= dx) begin
      state_o.lcase = mlr_pkg::LC_SHALLOW_POS;
      state_o.inc_a = dy <<< 1;
      state_o.inc_b = (dy - dx) <<< 1;
      dec           = (dy <<< 1) - dx;
    end else if (dy > 0) begin
      state_o.lcase = mlr_pkg::LC_STEEP_POS;
      state_o.inc_a = (dy - dx) <<< 1;
      state_o.inc_b = -(dx <<< 1);
      dec           = dy - (dx <<< 1);
    end else if (neg_dy <= dx) begin
      state_o.lcase = mlr_pkg::LC_SHALLOW_NEG;
      state_o.inc_a = (dy + dx) <<< 1;
      state_o.inc_b = dy <<< 1;
      dec           = (dy <<< 1) + dx;
    end else begin
      state_o.lcase = mlr_pkg::LC_STEEP_NEG;
      state_o.inc_a = dx <<< 1;
      state_o.inc_b = (dy + dx) <<< 1;
      dec           = dy + (dx <<< 1);
    end
    state_o.decision = {{(mlr_pkg::DEC_BITS - mlr_pkg::INC_BITS){dec[mlr_pkg::INC_BITS-1]}},
                        dec};
  end

endmodule

FILE: rtl/mlr_step.sv
// One midpoint step: emit the current pixel and move to the next one.
module mlr_step (
  input  mlr_pkg::line_state_t state_i,
  output mlr_pkg::out_beat_t   beat_o,
  output mlr_pkg::line_state_t state_o
);

  localparam int SEXT = mlr_pkg::DEC_BITS - mlr_pkg::INC_BITS;

  logic                         low_d;
  logic                         last;
  logic [mlr_pkg::DEC_BITS-1:0] inc_sel;

  always_comb begin
    low_d   = $signed(state_i.decision) <= 0;
    inc_sel = low_d ? {{SEXT{state_i.inc_a[mlr_pkg::INC_BITS-1]}}, state_i.inc_a}
                    : {{SEXT{state_i.inc_b[mlr_pkg::INC_BITS-1]}}, state_i.inc_b};

    case (state_i.lcase)
      mlr_pkg::LC_VERT,
      mlr_pkg::LC_STEEP_POS,
      mlr_pkg::LC_STEEP_NEG: last = state_i.cur_y == state_i.stop_y;
      default:               last = state_i.cur_x == state_i.stop_x;
    endcase

    state_o = state_i;
    beat_o  = '0;

    if (state_i.active) begin
      beat_o.pixel_x     = state_i.cur_x;
      beat_o.pixel_y     = state_i.cur_y;
      beat_o.pixel_valid = 1'b1;
      beat_o.last_pixel  = last;

      if (last) begin
        state_o.active = 1'b0;
      end else begin
        state_o.decision = state_i.decision + inc_sel;
        case (state_i.lcase)
          mlr_pkg::LC_VERT: begin
            state_o.cur_y = state_i.cur_y + 1'b1;
          end
          mlr_pkg::LC_HORIZ: begin
            state_o.cur_x = state_i.cur_x + 1'b1;
          end
          mlr_pkg::LC_SHALLOW_POS: begin
            state_o.cur_x = state_i.cur_x + 1'b1;
            if (!low_d) state_o.cur_y = state_i.cur_y + 1'b1;
          end
          mlr_pkg::LC_STEEP_POS: begin
            state_o.cur_y = state_i.cur_y + 1'b1;
            if (low_d) state_o.cur_x = state_i.cur_x + 1'b1;
          end
          mlr_pkg::LC_SHALLOW_NEG: begin
            state_o.cur_x = state_i.cur_x + 1'b1;
            if (low_d) state_o.cur_y = state_i.cur_y - 1'b1;
          end
          default: begin
            state_o.cur_y = state_i.cur_y - 1'b1;
            if (!low_d) state_o.cur_x = state_i.cur_x + 1'b1;
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/midpoint_line_rasterizer.sv
// Top level of the midpoint line rasterizer: input register, setup and step logic, line state and result registers.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_beat_i  (mlr_pkg::in_beat_t)
//   out     | output    | out_valid_o / out_stall_i | out_beat_o (mlr_pkg::out_beat_t)
//
// Every in beat gives exactly one out beat, through the input register and then the
// result register; one beat per cycle sustained while out is not stalled. The setup path
// (swap, subtract, slope compare) feeds the step path (compare, add) combinationally.
// Reset (rst_ni low, async) empties both registers and leaves the block idle.
// A stall on out holds the result register; the input register then holds too
// and in_stall_o rises, so nothing is dropped.
module midpoint_line_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mlr_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mlr_pkg::out_beat_t out_beat_o
);

  // input register
  logic              in_vld_q;
  mlr_pkg::in_beat_t in_q;

  // line state
  mlr_pkg::line_state_t state_q, state_d;
  mlr_pkg::line_state_t setup_state, step_src;

  // result register
  logic               out_vld_q;
  mlr_pkg::out_beat_t out_q, out_d;

  logic in_take;
  logic fire;

  assign in_take    = in_valid_i && !in_stall_o;
  // the held beat moves on unless the result register is full and stalled
  assign fire       = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;

  mlr_setup u_setup (
    .beat_i  (in_q),
    .state_o (setup_state)
  );

  // a start beat steps from the fresh setup, an advance from the held state
  assign step_src = (in_q.func == mlr_pkg::FUNC_START) ? setup_state : state_q;

  mlr_step u_step (
    .state_i (step_src),
    .beat_o  (out_d),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (fire) begin
      state_q   <= state_d;
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

endmodule

FILE: rtl/mlr_checker.sv
// Port-level checks of the midpoint line rasterizer, bound to the top level.
`include "midpoint_line_rasterizer_assert.svh"

module mlr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input mlr_pkg::in_beat_t  in_beat_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input mlr_pkg::out_beat_t out_beat_i
);

  `MLR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i,
    out_valid_i && $stable(out_beat_i), "stalled out beat changed")

  `MLR_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_i,
    out_valid_i && out_stall_i, "input stalled while output free")

  `MLR_ASSERT_SAME(a_idle_pixel, clk_i, rst_ni, out_valid_i && !out_beat_i.pixel_valid,
    !out_beat_i.last_pixel && out_beat_i.pixel_x == '0 && out_beat_i.pixel_y == '0,
    "invalid pixel carries data")

  `MLR_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_i,
    in_valid_i && $stable(in_beat_i), "stalled in beat changed")

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_i  (out_beat_o)
);
